[sv/ips_pkg.sv]
// Package for the interactivity priority scorer: widths, command and
// register codes, controller states and the divider request/response types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ips_pkg;

  // Width of the run and sleep time counters.
  localparam int CNT_W  = 32;
  // Width of the system tick count.
  localparam int TICK_W = 32;
  // Width of the wakeup sum, wide enough to catch saturation.
  localparam int SUM_W  = ((CNT_W > TICK_W) ? CNT_W : TICK_W) + 1;
  // Width of the divider's bit counter, able to hold CNT_W itself.
  localparam int CNT_CW = $clog2(CNT_W + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int CMD_W      = 3;
  localparam int INTER_W    = 9;
  localparam int SCORE_W    = 9;
  localparam int PRIO_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int NICE_W     = 6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SLEEP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRIO  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NICE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMESHARE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV1,
    ST_DIV2,
    ST_PDIV,
    ST_PMUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[sv/ips_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ips_pkg for widths and the request/response structs.
`default_nettype none

module ips_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ips_pkg::div_req_t req,
  output ips_pkg::div_rsp_t      rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [ips_pkg::CNT_CW-1:0]   cnt_r, cnt_nxt;
  logic [ips_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [ips_pkg::CNT_W-1:0]    quo_r, quo_nxt;
  logic [ips_pkg::CNT_W-1:0]    dsr_r, dsr_nxt;
  logic [ips_pkg::CNT_W+1:0]    trial;

  // The dividend shifts out of the top of quo_r while quotient bits
  // shift in at the bottom.
  assign trial = {1'b0, rem_r, quo_r[ips_pkg::CNT_W-1]} - {2'b00, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ips_pkg::CNT_CW'(ips_pkg::CNT_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[ips_pkg::CNT_W+1]) begin
        rem_nxt = trial[ips_pkg::CNT_W-1:0];
        quo_nxt = {quo_r[ips_pkg::CNT_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[ips_pkg::CNT_W-2:0], quo_r[ips_pkg::CNT_W-1]};
        quo_nxt = {quo_r[ips_pkg::CNT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - ips_pkg::CNT_CW'(1);
      if (cnt_r == ips_pkg::CNT_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

[sv/interactivity_priority_scorer.sv]
// Interactivity scorer and priority mapper for one thread, one request at a time.
// An accepted request passes through ST_DECODE to ST_OUT; a score query that needs
// both divisions runs ST_DIV1 and ST_DIV2 in between, and a priority update that
// divides runs ST_PDIV and ST_PMUL; the bit-serial divider (one quotient bit per
// cycle) makes those two the long sequences. A full, stalled result holds ST_OUT.
// Synchronous reset clears counters, latch and priority and loads register defaults.
`default_nettype none

module interactivity_priority_scorer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [ips_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ips_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Request channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ips_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [ips_pkg::TICK_W-1:0]       in_now_ticks,
  input  wire logic [ips_pkg::INTER_W-1:0]      in_stored_interactivity,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ips_pkg::SCORE_W-1:0]           out_score,
  output logic [ips_pkg::PRIO_W-1:0]            out_priority_res
);

  ips_pkg::state_t state_r, state_nxt;

  // Captured request.
  logic [ips_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ips_pkg::TICK_W-1:0]   now_r, now_nxt;
  logic [ips_pkg::INTER_W-1:0]  inter_r, inter_nxt;

  // Thread state.
  logic [ips_pkg::CNT_W-1:0]    run_r, run_nxt;
  logic [ips_pkg::CNT_W-1:0]    sleep_r, sleep_nxt;
  logic [ips_pkg::TICK_W-1:0]   start_r, start_nxt;
  logic [ips_pkg::PRIO_W-1:0]   prio_r, prio_nxt;

  // Configuration registers.
  logic [7:0]                   half_r, thr_r, pmin_r, pmax_r;
  logic [ips_pkg::NICE_W-1:0]   nice_r;
  logic                         ts_r;

  // Working registers of the score and priority sequences.
  logic                         gt_r, gt_nxt;
  logic                         neg_r, neg_nxt;
  logic [7:0]                   s_r, s_nxt;
  logic [7:0]                   prod_r, prod_nxt;
  logic [ips_pkg::SCORE_W-1:0]  score_r, score_nxt;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic [ips_pkg::SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [ips_pkg::PRIO_W-1:0]   out_prio_r, out_prio_nxt;

  ips_pkg::div_req_t            div_req;
  ips_pkg::div_rsp_t            div_rsp;

  // Derived values.
  logic [7:0]                   h;
  logic                         run_eq, run_ge, run_gt, keep_half;
  logic [ips_pkg::TICK_W-1:0]   elapsed;
  logic [ips_pkg::SUM_W-1:0]    wake_sum;
  logic [ips_pkg::CNT_W-1:0]    sleep_add, run_inc;
  logic [10:0]                  s_sum;
  logic [9:0]                   s_cl;
  logic                         s_ge;
  logic [9:0]                   span, span_mag;
  logic [ips_pkg::CNT_W-1:0]    d2;
  logic                         q_ge_h;
  logic [15:0]                  mul;
  logic [7:0]                   prod;
  logic                         accept, out_load;

  ips_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // A half of zero behaves as one.
  assign h = (half_r == 8'd0) ? 8'd1 : half_r;

  assign run_eq    = (run_r == sleep_r);
  assign run_ge    = (run_r >= sleep_r);
  assign run_gt    = run_ge && !run_eq;
  assign keep_half = (({1'b0, inter_r} <= {2'b00, h}) && run_ge) || run_eq;

  // Saturating counter updates. Elapsed sleep wraps modulo the tick width.
  assign run_inc   = (run_r == ips_pkg::CNT_MAX) ? run_r : run_r + ips_pkg::CNT_W'(1);
  assign elapsed   = now_r - start_r;
  assign wake_sum  = ips_pkg::SUM_W'(sleep_r) + ips_pkg::SUM_W'(elapsed);
  assign sleep_add = (wake_sum > ips_pkg::SUM_W'(ips_pkg::CNT_MAX)) ?
                     ips_pkg::CNT_MAX : wake_sum[ips_pkg::CNT_W-1:0];

  // Interactivity plus nice, clamped at zero, against the threshold.
  assign s_sum = {2'b00, inter_r} + {{5{nice_r[ips_pkg::NICE_W-1]}}, nice_r};
  assign s_cl  = s_sum[10] ? 10'd0 : s_sum[9:0];
  assign s_ge  = (s_cl >= {2'b00, thr_r});

  // Signed span of the interactive range; the division runs on its magnitude
  // and the sign comes back afterwards, which truncates toward zero.
  assign span     = {2'b00, pmax_r} - {2'b00, pmin_r} + 10'd1;
  assign span_mag = span[9] ? (~span + 10'd1) : span;

  // The first quotient becomes the second divisor, never below one.
  assign d2     = (div_rsp.quotient == '0) ? ips_pkg::CNT_W'(1) : div_rsp.quotient;
  assign q_ge_h = (div_rsp.quotient >= ips_pkg::CNT_W'(h));

  // Only the low byte of the step times the clamped sum survives.
  assign mul  = div_rsp.quotient[7:0] * s_r;
  assign prod = neg_r ? (~mul[7:0] + 8'd1) : mul[7:0];

  assign accept   = in_valid && (state_r == ips_pkg::ST_IDLE);
  assign out_load = (state_r == ips_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ips_pkg::ST_IDLE: begin
        if (accept) state_nxt = ips_pkg::ST_DECODE;
      end
      ips_pkg::ST_DECODE: begin
        state_nxt = ips_pkg::ST_OUT;
        if (cmd_r == ips_pkg::CMD_QUERY && !keep_half) begin
          state_nxt = ips_pkg::ST_DIV1;
        end else if (cmd_r == ips_pkg::CMD_PRIO && ts_r && !s_ge) begin
          state_nxt = ips_pkg::ST_PDIV;
        end
      end
      ips_pkg::ST_DIV1: begin
        if (div_rsp.done) state_nxt = ips_pkg::ST_DIV2;
      end
      ips_pkg::ST_DIV2: begin
        if (div_rsp.done) state_nxt = ips_pkg::ST_OUT;
      end
      ips_pkg::ST_PDIV: begin
        if (div_rsp.done) state_nxt = ips_pkg::ST_PMUL;
      end
      ips_pkg::ST_PMUL: state_nxt = ips_pkg::ST_OUT;
      ips_pkg::ST_OUT: begin
        if (out_load) state_nxt = ips_pkg::ST_IDLE;
      end
      default: state_nxt = ips_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and divider requests.
  always_comb begin
    cmd_nxt          = cmd_r;
    now_nxt          = now_r;
    inter_nxt        = inter_r;
    run_nxt          = run_r;
    sleep_nxt        = sleep_r;
    start_nxt        = start_r;
    prio_nxt         = prio_r;
    gt_nxt           = gt_r;
    neg_nxt          = neg_r;
    s_nxt            = s_r;
    prod_nxt         = prod_r;
    score_nxt        = score_r;
    div_req.start    = 1'b0;
    div_req.dividend = run_r;
    div_req.divisor  = ips_pkg::CNT_W'(h);

    case (state_r)
      ips_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          now_nxt   = in_now_ticks;
          inter_nxt = in_stored_interactivity;
        end
      end
      ips_pkg::ST_DECODE: begin
        score_nxt = '0;
        case (cmd_r)
          ips_pkg::CMD_TICK: run_nxt = run_inc;
          ips_pkg::CMD_SLEEP: start_nxt = now_r;
          ips_pkg::CMD_WAKE: begin
            sleep_nxt = sleep_add;
            start_nxt = '0;
          end
          ips_pkg::CMD_QUERY: begin
            gt_nxt = run_gt;
            if (keep_half) begin
              score_nxt = ips_pkg::SCORE_W'(h);
            end else begin
              // First division: the larger counter over the half scale.
              div_req.start    = 1'b1;
              div_req.dividend = run_gt ? run_r : sleep_r;
              div_req.divisor  = ips_pkg::CNT_W'(h);
            end
          end
          ips_pkg::CMD_PRIO: begin
            if (!ts_r || s_ge) begin
              prio_nxt = '0;
            end else begin
              s_nxt            = s_cl[7:0];
              neg_nxt          = span[9];
              div_req.start    = 1'b1;
              div_req.dividend = ips_pkg::CNT_W'(span_mag);
              div_req.divisor  = ips_pkg::CNT_W'(thr_r);
            end
          end
          default: ;
        endcase
      end
      ips_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          // Second division: the smaller counter over the first quotient.
          div_req.start    = 1'b1;
          div_req.dividend = gt_r ? sleep_r : run_r;
          div_req.divisor  = d2;
        end
      end
      ips_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          if (gt_r) begin
            // The term below half is clamped at zero.
            score_nxt = q_ge_h ? ips_pkg::SCORE_W'(h) :
                        ips_pkg::SCORE_W'(h) + ips_pkg::SCORE_W'(h) -
                        ips_pkg::SCORE_W'(div_rsp.quotient[7:0]);
          end else begin
            score_nxt = div_rsp.quotient[ips_pkg::SCORE_W-1:0];
          end
        end
      end
      ips_pkg::ST_PDIV: begin
        if (div_rsp.done) prod_nxt = prod;
      end
      ips_pkg::ST_PMUL: prio_nxt = pmin_r + prod_r;
      default: ;
    endcase
  end

  // Result register: it loads when empty or draining, and empties on handoff.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_score_nxt = out_score_r;
    out_prio_nxt  = out_prio_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_score_nxt = score_r;
      out_prio_nxt  = prio_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ips_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      run_r       <= '0;
      sleep_r     <= '0;
      start_r     <= '0;
      prio_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      sleep_r     <= sleep_nxt;
      start_r     <= start_nxt;
      prio_r      <= prio_nxt;
    end
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    inter_r     <= inter_nxt;
    gt_r        <= gt_nxt;
    neg_r       <= neg_nxt;
    s_r         <= s_nxt;
    prod_r      <= prod_nxt;
    score_r     <= score_nxt;
    out_score_r <= out_score_nxt;
    out_prio_r  <= out_prio_nxt;
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 8'd50;
      thr_r  <= 8'd30;
      pmin_r <= 8'd120;
      pmax_r <= 8'd159;
      nice_r <= '0;
      ts_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        ips_pkg::REG_HALF:      half_r <= cfg_data;
        ips_pkg::REG_THRESHOLD: thr_r  <= cfg_data;
        ips_pkg::REG_PRIO_MIN:  pmin_r <= cfg_data;
        ips_pkg::REG_PRIO_MAX:  pmax_r <= cfg_data;
        ips_pkg::REG_NICE:      nice_r <= cfg_data[ips_pkg::NICE_W-1:0];
        ips_pkg::REG_TIMESHARE: ts_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall         = (state_r != ips_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_score        = out_score_r;
  assign out_priority_res = out_prio_r;

endmodule

`default_nettype wire
